// ===== rtl/core/mish_pkg.sv =====
package mish_pkg;

  localparam int unsigned DATA_WIDTH = 16;
  localparam int unsigned FRAC_BITS  = 11;

  // Internal fractional precision of exp, tanh and the quotient.
  localparam int unsigned PREC       = DATA_WIDTH + 24;
  localparam int unsigned MW         = PREC + 1;
  localparam int unsigned MH         = (MW + 1) / 2;
  localparam int unsigned NUM_W      = PREC + 3;
  localparam int unsigned INT_W      = DATA_WIDTH - FRAC_BITS;

  localparam int unsigned CHUNK_W     = (FRAC_BITS + 2) / 3;
  localparam int unsigned CHUNK_DEPTH = 1 << CHUNK_W;
  localparam int unsigned EXP_CAP     = 64;
  localparam int unsigned EN_DEPTH    = EXP_CAP + 1;
  localparam int unsigned EN_IDX_W    = $clog2(EN_DEPTH);
  localparam int unsigned SERIES_TERMS = 27;

  localparam int unsigned DIV_STAGES = PREC + 1;
  localparam int unsigned LATENCY    = PREC + 13;

  localparam int unsigned LL_W   = 2 * MH;
  localparam int unsigned HH_W   = 2 * (MW - MH);
  localparam int unsigned FULL_W = 2 * MW;

  localparam logic [63:0] ONE62 = 64'd1 << 62;

  typedef logic [MW-1:0] mish_fx_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_value;
    logic                         last_in;
  } mish_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] y_value;
    logic                         last_out;
  } mish_out_t;

  // Per-element information carried alongside the arithmetic.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] mag;
    logic                  neg;
    logic                  last;
  } mish_side_t;

  // Partial products of an MW x MW multiply, split at bit MH.
  typedef struct packed {
    logic [LL_W-1:0] ll;
    logic [MW-1:0]   lh;
    logic [MW-1:0]   hl;
    logic [HH_W-1:0] hh;
  } mish_pp_t;

  typedef mish_fx_t en_tab_t [EN_DEPTH];
  typedef mish_fx_t chunk_tab_t [CHUNK_DEPTH];

  function automatic mish_pp_t mul_pp(input mish_fx_t a, input mish_fx_t b);
    mish_pp_t pp;
    pp.ll = LL_W'(a[MH-1:0]) * LL_W'(b[MH-1:0]);
    pp.lh = MW'(a[MH-1:0]) * MW'(b[MW-1:MH]);
    pp.hl = MW'(a[MW-1:MH]) * MW'(b[MH-1:0]);
    pp.hh = HH_W'(a[MW-1:MH]) * HH_W'(b[MW-1:MH]);
    return pp;
  endfunction

  // Sums the partial products and drops PREC fraction bits (truncating).
  function automatic mish_fx_t mul_fin(input mish_pp_t pp);
    logic [FULL_W-1:0] full;
    full = FULL_W'(pp.ll) + (FULL_W'(pp.lh) << MH) + (FULL_W'(pp.hl) << MH)
         + (FULL_W'(pp.hh) << (2 * MH));
    return MW'(full >> PREC);
  endfunction

  // Truncating quotient of two 64-bit values by long division; used only to
  // build the constant tables.
  function automatic logic [63:0] quot_u64(input logic [63:0] a, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-r) for 0 <= r <= 1 in Q2.62, Horner form of the Taylor series.
  function automatic logic [63:0] exp_neg_q62(input logic [63:0] r);
    logic [127:0] p;
    logic [63:0]  res;
    int unsigned  k;
    res = ONE62;
    for (k = SERIES_TERMS; k >= 1; k--) begin
      p   = 128'(r) * 128'(res);
      res = ONE62 - quot_u64(64'(p >> 62), 64'(k));
    end
    return res;
  endfunction

  function automatic mish_fx_t q62_to_fx(input logic [63:0] q);
    return MW'((q + (64'd1 << (61 - PREC))) >> (62 - PREC));
  endfunction

  function automatic en_tab_t build_en_tab();
    en_tab_t      tab;
    logic [63:0]  e1;
    logic [63:0]  cur;
    logic [127:0] p;
    e1  = exp_neg_q62(ONE62);
    cur = ONE62;
    for (int i = 0; i < EN_DEPTH; i++) begin
      tab[i] = q62_to_fx(cur);
      p      = 128'(cur) * 128'(e1);
      cur    = 64'(p >> 62);
    end
    return tab;
  endfunction

  function automatic chunk_tab_t build_chunk_tab(input int unsigned offset);
    chunk_tab_t  tab;
    logic [63:0] r;
    for (int c = 0; c < CHUNK_DEPTH; c++) begin
      if (c < (1 << (FRAC_BITS - offset))) begin
        r      = 64'(c) << (offset + 62 - FRAC_BITS);
        tab[c] = q62_to_fx(exp_neg_q62(r));
      end else begin
        tab[c] = '0;
      end
    end
    return tab;
  endfunction

  // exp(-n) for the integer part, exp(-g) for three slices of the fraction.
  localparam en_tab_t    EN_TAB     = build_en_tab();
  localparam chunk_tab_t CHUNK0_TAB = build_chunk_tab(0);
  localparam chunk_tab_t CHUNK1_TAB = build_chunk_tab(CHUNK_W);
  localparam chunk_tab_t CHUNK2_TAB = build_chunk_tab(2 * CHUNK_W);

endpackage

// ===== rtl/core/mish_div.sv =====
module mish_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [mish_pkg::NUM_W-1:0] num_i,
  input  logic [mish_pkg::NUM_W-1:0] den_i,
  input  mish_pkg::mish_side_t      side_i,
  output logic                      valid_o,
  output mish_pkg::mish_fx_t        quot_o,
  output mish_pkg::mish_side_t      side_o
);
  import mish_pkg::*;

  // One quotient bit per stage; the first stage yields the integer bit.
  logic [DIV_STAGES-1:0] vld_q;
  logic [NUM_W-1:0]      rem_q  [DIV_STAGES-1];
  logic [NUM_W-1:0]      den_q  [DIV_STAGES-1];
  mish_fx_t              quo_q  [DIV_STAGES];
  mish_side_t            side_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [NUM_W:0]   trial;
    logic [NUM_W-1:0] den_in;
    mish_fx_t         quo_in;
    mish_side_t       side_in;
    logic             valid_in;
    logic             ge;
    logic [NUM_W-1:0] rem_d;
    mish_fx_t         quo_d;

    if (s == 0) begin : g_first
      always_comb begin
        trial    = (NUM_W + 1)'(num_i);
        den_in   = den_i;
        quo_in   = '0;
        side_in  = side_i;
        valid_in = valid_i;
      end
    end else begin : g_next
      always_comb begin
        trial    = {rem_q[s-1], 1'b0};
        den_in   = den_q[s-1];
        quo_in   = quo_q[s-1];
        side_in  = side_q[s-1];
        valid_in = vld_q[s-1];
      end
    end

    always_comb begin
      ge    = trial >= {1'b0, den_in};
      rem_d = ge ? NUM_W'(trial - {1'b0, den_in}) : NUM_W'(trial);
      quo_d = {quo_in[MW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[s]  <= quo_d;
      side_q[s] <= side_in;
    end

    if (s < DIV_STAGES - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        rem_q[s] <= rem_d;
        den_q[s] <= den_in;
      end
    end
  end

  assign valid_o = vld_q[DIV_STAGES-1];
  assign quot_o  = quo_q[DIV_STAGES-1];
  assign side_o  = side_q[DIV_STAGES-1];

`ifndef ASSERT_OFF
  // The tanh factor never exceeds one.
  a_quot_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (quot_o <= (MW'(1) << PREC)))
    else $error("mish_div: quotient above one");

  a_valid_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, DIV_STAGES))
    else $error("mish_div: result without matching operand");
`endif

endmodule

// ===== rtl/core/mish_activation_top.sv =====
// Mish activation, y = x * tanh(softplus(x)), one element per clock.
// Throughput: one transaction per cycle; busy_o is never raised and the
// receiver cannot stall, so each result is shown for exactly one cycle.
// The depth is set by the bit-per-stage divider that forms the tanh factor.
// Reset clears all valid bits; the datapath registers are not reset.
module mish_activation_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  mish_pkg::mish_in_t  item_i,
  output logic                busy_o,
  output logic                done_o,
  output mish_pkg::mish_out_t result_o
);
  import mish_pkg::*;

  localparam int unsigned PRE_STAGES = 9;
  localparam int unsigned ML_W   = DATA_WIDTH + MH;
  localparam int unsigned MHI_W  = DATA_WIDTH + MW - MH;
  localparam int unsigned PROD_W = DATA_WIDTH + MW + 1;

  logic [PRE_STAGES-1:0] vld_q;
  mish_side_t            side_q [PRE_STAGES];

  mish_side_t            side_d;
  logic [INT_W-1:0]      int_part;
  logic [EN_IDX_W-1:0]   en_idx_d;
  logic [CHUNK_W-1:0]    c0_d, c1_d, c2_d;

  mish_fx_t  en_q, c0_q, c1_q, c2_q;
  mish_pp_t  pp_a_q, pp_b_q;
  mish_fx_t  pa_q, pb_q;
  mish_pp_t  pp_v_q;
  mish_fx_t  v_f_q, v_g_q, v_h_q;
  mish_pp_t  pp_sq_q;
  mish_fx_t  v2_q;
  logic [NUM_W-1:0] num_d, den_d, num_q, den_q;

  logic       div_vld;
  mish_fx_t   div_quot;
  mish_side_t div_side;

  logic [ML_W-1:0]       ml_q;
  logic [MHI_W-1:0]      mh_q;
  mish_side_t            side_j_q, side_k_q;
  logic [PROD_W-1:0]     prod_d;
  logic [DATA_WIDTH-1:0] m_q;
  logic                  vld_j_q, vld_k_q, done_q;
  mish_out_t             result_q;

  assign busy_o = 1'b0;

  always_comb begin
    side_d.neg  = item_i.x_value[DATA_WIDTH-1];
    side_d.mag  = side_d.neg ? DATA_WIDTH'(-item_i.x_value) : DATA_WIDTH'(item_i.x_value);
    side_d.last = item_i.last_in;
  end

  // Table indexes: integer part clamped at the cap, fraction in three slices.
  always_comb begin
    int_part = side_q[0].mag[DATA_WIDTH-1:FRAC_BITS];
    en_idx_d = (32'(int_part) > EXP_CAP) ? EN_IDX_W'(EXP_CAP) : EN_IDX_W'(int_part);
    c0_d     = side_q[0].mag[CHUNK_W-1:0];
    c1_d     = side_q[0].mag[2*CHUNK_W-1:CHUNK_W];
    c2_d     = CHUNK_W'(side_q[0].mag[FRAC_BITS-1:2*CHUNK_W]);
  end

  // With v = exp(-|x|): tanh(softplus(x)) = (1+2v)/(1+2v+2v^2) for x >= 0,
  // and (v^2+2v)/(v^2+2v+2) for x < 0.
  always_comb begin
    if (side_q[7].neg) begin
      num_d = NUM_W'(v2_q) + (NUM_W'(v_h_q) << 1);
      den_d = num_d + (NUM_W'(2) << PREC);
    end else begin
      num_d = (NUM_W'(1) << PREC) + (NUM_W'(v_h_q) << 1);
      den_d = num_d + (NUM_W'(v2_q) << 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PRE_STAGES-2:0], start_i & ~busy_o};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < PRE_STAGES; i++) begin
      side_q[i] <= side_q[i-1];
    end
    en_q    <= EN_TAB[en_idx_d];
    c0_q    <= CHUNK0_TAB[c0_d];
    c1_q    <= CHUNK1_TAB[c1_d];
    c2_q    <= CHUNK2_TAB[c2_d];
    pp_a_q  <= mul_pp(en_q, c2_q);
    pp_b_q  <= mul_pp(c1_q, c0_q);
    pa_q    <= mul_fin(pp_a_q);
    pb_q    <= mul_fin(pp_b_q);
    pp_v_q  <= mul_pp(pa_q, pb_q);
    v_f_q   <= mul_fin(pp_v_q);
    pp_sq_q <= mul_pp(v_f_q, v_f_q);
    v_g_q   <= v_f_q;
    v2_q    <= mul_fin(pp_sq_q);
    v_h_q   <= v_g_q;
    num_q   <= num_d;
    den_q   <= den_d;
  end

  mish_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[PRE_STAGES-1]),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (side_q[PRE_STAGES-1]),
    .valid_o (div_vld),
    .quot_o  (div_quot),
    .side_o  (div_side)
  );

  // |y| = round(|x| * t), halves rounding up.
  always_comb begin
    prod_d = PROD_W'(ml_q) + (PROD_W'(mh_q) << MH) + (PROD_W'(1) << (PREC - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_j_q <= 1'b0;
      vld_k_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      vld_j_q <= div_vld;
      vld_k_q <= vld_j_q;
      done_q  <= vld_k_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ml_q     <= ML_W'(div_side.mag) * ML_W'(div_quot[MH-1:0]);
    mh_q     <= MHI_W'(div_side.mag) * MHI_W'(div_quot[MW-1:MH]);
    side_j_q <= div_side;
    m_q      <= DATA_WIDTH'(prod_d >> PREC);
    side_k_q <= side_j_q;
    result_q.y_value  <= side_k_q.neg ? DATA_WIDTH'(-m_q) : m_q;
    result_q.last_out <= side_k_q.last;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef ASSERT_OFF
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LATENCY))
    else $error("mish: result without an accepted transaction");

  a_last_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.last_out == $past(item_i.last_in, LATENCY)))
    else $error("mish: last mark does not follow its element");

  a_pos_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !$past(item_i.x_value[DATA_WIDTH-1], LATENCY)) |->
      (!result_o.y_value[DATA_WIDTH-1] &&
       ($signed(result_o.y_value) <= $signed($past(item_i.x_value, LATENCY)))))
    else $error("mish: result for non-negative input outside [0, x]");

  a_neg_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(item_i.x_value[DATA_WIDTH-1], LATENCY)) |->
      ($signed(result_o.y_value) <= 0))
    else $error("mish: positive result for negative input");
`endif

endmodule
